// ===== rtl/bcf_pkg.sv =====
// ----------------------------------------------------------------------------
// bcf_pkg: shared definitions of the biquad cascade filter
// Holds field widths, fixed-point constants, action and register codes,
// datapath control types and the saturation helpers.
// ----------------------------------------------------------------------------
package bcf_pkg;

  // Transaction field widths.
  localparam int ACT_W    = 2;
  localparam int SAMPLE_W = 24;
  localparam int COEFF_W  = 32;
  localparam int IDX_W    = 5;

  // Fixed-point formats: samples Q1.23, coefficients Q5.26, delays 2^-39.
  localparam int SAMPLE_FRAC = SAMPLE_W - 1;
  localparam int COEFF_FRAC  = COEFF_W - 6;
  localparam int DLY_W       = 48;
  localparam int DLY_FRAC    = 39;
  localparam int PROD_W      = SAMPLE_W + COEFF_W;
  localparam int PROD_SHIFT  = SAMPLE_FRAC + COEFF_FRAC - DLY_FRAC;
  localparam int TERM_W      = PROD_W - PROD_SHIFT;
  localparam int ACC_W       = DLY_W + 2;
  localparam int RND_SHIFT   = DLY_FRAC - SAMPLE_FRAC;
  localparam int RSH_W       = DLY_W + 1 - RND_SHIFT;

  // Coefficients per section and their position inside a section.
  localparam int NCOEF  = 5;
  localparam int POS_B2 = 0;
  localparam int POS_B1 = 1;
  localparam int POS_B0 = 2;
  localparam int POS_A2 = 3;
  localparam int POS_A1 = 4;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_FILTER_ENABLE = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_FILTER = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_DLY,
    ACC_LOAD_TERM,
    ACC_ADD_TERM,
    ACC_SUB_TERM
  } acc_op_e;

  typedef enum logic [1:0] {
    X_HOLD,
    X_LOAD_SAMPLE,
    X_LOAD_Y
  } x_op_e;

  typedef struct packed {
    logic    mul_en;
    logic    mul_y;
    acc_op_e acc_op;
    acc_op_e acc2_op;
    logic    yd_en;
    logic    y_en;
    x_op_e   x_op;
  } dp_ctrl_t;

  // Saturate an accumulator to the delay width.
  function automatic logic [DLY_W-1:0] sat_dly(input logic [ACC_W-1:0] v);
    logic [DLY_W-1:0] res;
    if ((&v[ACC_W-1:DLY_W-1]) || !(|v[ACC_W-1:DLY_W-1])) begin
      res = v[DLY_W-1:0];
    end else if (v[ACC_W-1]) begin
      res = {1'b1, {(DLY_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(DLY_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Saturate a rounded, shifted value to the sample width.
  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [RSH_W-1:0] v);
    logic [SAMPLE_W-1:0] res;
    if ((&v[RSH_W-1:SAMPLE_W-1]) || !(|v[RSH_W-1:SAMPLE_W-1])) begin
      res = v[SAMPLE_W-1:0];
    end else if (v[RSH_W-1]) begin
      res = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ===== rtl/bcf_ifs.sv =====
// ----------------------------------------------------------------------------
// bcf_ifs: channel interfaces of the biquad cascade filter
// Input channel carries commands and samples, output channel the results.
// ----------------------------------------------------------------------------
interface bcf_in_if import bcf_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [ACT_W-1:0]           action;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [IDX_W-1:0]           coeff_index;
  logic signed [COEFF_W-1:0]  coeff_value;

  modport source (output valid, action, sample_in, coeff_index, coeff_value,
                  input ready);
  modport sink (input valid, action, sample_in, coeff_index, coeff_value,
                output ready);
endinterface

interface bcf_out_if import bcf_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

// ===== rtl/biquad_cascade_filter_top.sv =====
// ----------------------------------------------------------------------------
// biquad_cascade_filter_top: cascaded biquad audio filter
// Top level with command sequencer, configuration register, coefficient
// and delay stores, shared datapath and output register.
// ----------------------------------------------------------------------------
// The block filters signed 24-bit samples through STAGES biquad sections in
// transposed direct form II, each section feeding the next, and returns one
// rounded, saturated sample per filter transaction. A write transaction loads
// one Q5.26 coefficient (slot = section*5 + position, positions b2, b1, b0,
// a2, a1; slots beyond the store are ignored) and a clear transaction zeroes
// all delay state; both finish in the cycle they are accepted and return
// nothing, as does the unused action code. With filter_enable low, a filter
// transaction returns the unchanged input as its result and leaves the delay
// state alone. With filter_enable high, one multiplier is shared by the five
// products of each section, and each section walks the single read port of
// the coefficient store and of the delay store in turn. One transaction is
// in work at a time; the next is accepted once the result sits in the output
// register, so a stalled output holds off the input while an earlier
// result still waits there. Both stores come out of reset reading zero
// through per-entry valid bits, so no clearing pass is needed, and a
// clear transaction takes effect at once. Filter_enable sits at byte
// address 0 of the register port.
// ----------------------------------------------------------------------------
module biquad_cascade_filter_top import bcf_pkg::*; #(
  parameter int STAGES = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bcf_in_if.sink                in_i,
  bcf_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int NCOEF_TOT = NCOEF * STAGES;
  localparam int NDLY      = 2 * STAGES;
  localparam int CA_W      = $clog2(NCOEF_TOT);
  localparam int DA_W      = $clog2(NDLY);
  localparam int STG_W     = (STAGES > 1) ? $clog2(STAGES) : 1;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Phases of one section.
  localparam logic [3:0] PH_RD_B0  = 4'd0;
  localparam logic [3:0] PH_MUL_B0 = 4'd1;
  localparam logic [3:0] PH_MUL_B1 = 4'd2;
  localparam logic [3:0] PH_MUL_B2 = 4'd3;
  localparam logic [3:0] PH_ROUND  = 4'd4;
  localparam logic [3:0] PH_MUL_A1 = 4'd5;
  localparam logic [3:0] PH_MUL_A2 = 4'd6;
  localparam logic [3:0] PH_WR_S1  = 4'd7;
  localparam logic [3:0] PH_WR_S2  = 4'd8;

  logic [1:0]          state_q, state_d;
  logic [3:0]          phase_q, phase_d;
  logic [STG_W-1:0]    stage_q, stage_d;
  logic [CA_W-1:0]     cbase_q, cbase_d;
  logic [DA_W-1:0]     dbase_q, dbase_d;
  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_data_q, out_data_d;
  logic                filter_en_q;

  logic                in_fire, last_stage, cfg_wr;
  logic                coef_we, coef_re, dly_we, dly_re, dly_clear;
  logic [CA_W-1:0]     coef_raddr;
  logic [DA_W-1:0]     dly_raddr, dly_waddr;
  logic [DLY_W-1:0]    dly_wdata, dly_rdata, s1, s2;
  logic [COEFF_W-1:0]  coef_rdata;
  logic [SAMPLE_W-1:0] x_val;
  dp_ctrl_t            ctrl;

  assign in_fire    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign last_stage = (stage_q == STG_W'(STAGES - 1));

  // Register port: one register, written in the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FILTER_ENABLE);
  assign prdata = (paddr[2] == REG_FILTER_ENABLE) ?
                  {{(APB_DATA_W-1){1'b0}}, filter_en_q} : '0;

  // Coefficient writes and delay clears complete in the accepting cycle.
  assign coef_we   = in_fire && (in_i.action == ACT_WRITE) &&
                     ({{(32-IDX_W){1'b0}}, in_i.coeff_index} < 32'(NCOEF_TOT));
  assign dly_clear = in_fire && (in_i.action == ACT_CLEAR);
  assign coef_re   = (state_q == ST_RUN);
  assign dly_re    = (state_q == ST_RUN);

  // Sequencer. Every store access of a filter transaction belongs to a
  // single transaction and a section never reads an entry it has already
  // written back, so read and write of one entry never overlap and no
  // forwarding path is needed.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    stage_d     = stage_q;
    cbase_d     = cbase_q;
    dbase_d     = dbase_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ctrl        = '0;
    coef_raddr  = cbase_q + CA_W'(POS_B0);
    dly_raddr   = dbase_q;
    dly_we      = 1'b0;
    dly_waddr   = dbase_q;
    dly_wdata   = s1;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.action == ACT_FILTER)) begin
          ctrl.x_op = X_LOAD_SAMPLE;
          stage_d   = '0;
          cbase_d   = '0;
          dbase_d   = '0;
          phase_d   = PH_RD_B0;
          state_d   = filter_en_q ? ST_RUN : ST_DONE;
        end
      end
      ST_RUN: begin
        phase_d = phase_q + 4'd1;
        unique case (phase_q)
          PH_RD_B0: begin
            coef_raddr = cbase_q + CA_W'(POS_B0);
            dly_raddr  = dbase_q;
          end
          PH_MUL_B0: begin
            ctrl.mul_en = 1'b1;
            ctrl.acc_op = ACC_LOAD_DLY;
            coef_raddr  = cbase_q + CA_W'(POS_B1);
            dly_raddr   = dbase_q + DA_W'(1);
          end
          PH_MUL_B1: begin
            ctrl.mul_en  = 1'b1;
            ctrl.acc_op  = ACC_ADD_TERM;
            ctrl.acc2_op = ACC_LOAD_DLY;
            coef_raddr   = cbase_q + CA_W'(POS_B2);
          end
          PH_MUL_B2: begin
            ctrl.mul_en  = 1'b1;
            ctrl.yd_en   = 1'b1;
            ctrl.acc2_op = ACC_ADD_TERM;
          end
          PH_ROUND: begin
            ctrl.y_en   = 1'b1;
            ctrl.acc_op = ACC_LOAD_TERM;
            coef_raddr  = cbase_q + CA_W'(POS_A1);
          end
          PH_MUL_A1: begin
            ctrl.mul_en = 1'b1;
            ctrl.mul_y  = 1'b1;
            coef_raddr  = cbase_q + CA_W'(POS_A2);
          end
          PH_MUL_A2: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_y   = 1'b1;
            ctrl.acc2_op = ACC_SUB_TERM;
          end
          PH_WR_S1: begin
            ctrl.acc_op = ACC_SUB_TERM;
            dly_we      = 1'b1;
            dly_waddr   = dbase_q;
            dly_wdata   = s1;
          end
          PH_WR_S2: begin
            dly_we    = 1'b1;
            dly_waddr = dbase_q + DA_W'(1);
            dly_wdata = s2;
            ctrl.x_op = X_LOAD_Y;
            phase_d   = PH_RD_B0;
            stage_d   = stage_q + STG_W'(1);
            cbase_d   = cbase_q + CA_W'(NCOEF);
            dbase_d   = dbase_q + DA_W'(2);
            if (last_stage) begin
              state_d = ST_DONE;
            end
          end
          default: begin
            phase_d = PH_RD_B0;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_data_d  = x_val;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_RD_B0;
      stage_q     <= '0;
      cbase_q     <= '0;
      dbase_q     <= '0;
      out_valid_q <= 1'b0;
      filter_en_q <= 1'b1;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      stage_q     <= stage_d;
      cbase_q     <= cbase_d;
      dbase_q     <= dbase_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        filter_en_q <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  bcf_ram #(
    .DEPTH (NCOEF_TOT),
    .WIDTH (COEFF_W)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (1'b0),
    .we_i    (coef_we),
    .waddr_i (CA_W'(in_i.coeff_index)),
    .wdata_i (in_i.coeff_value),
    .re_i    (coef_re),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  bcf_ram #(
    .DEPTH (NDLY),
    .WIDTH (DLY_W)
  ) u_dly_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (dly_clear),
    .we_i    (dly_we),
    .waddr_i (dly_waddr),
    .wdata_i (dly_wdata),
    .re_i    (dly_re),
    .raddr_i (dly_raddr),
    .rdata_o (dly_rdata)
  );

  bcf_dp u_dp (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .sample_i (in_i.sample_in),
    .coeff_i  (coef_rdata),
    .dly_i    (dly_rdata),
    .x_o      (x_val),
    .s1_o     (s1),
    .s2_o     (s2)
  );

`ifndef ASSERT_OFF
  // A result only appears after the sequencer has finished a transaction.
  a_out_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the done state");

  // The section counter never runs past the last section.
  a_stage_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (32'(stage_q) < 32'(STAGES)))
    else $error("section counter out of range");

  // Delay state is written back only in the two write-back phases.
  a_dly_wr_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dly_we |-> ((state_q == ST_RUN) &&
               ((phase_q == PH_WR_S1) || (phase_q == PH_WR_S2))))
    else $error("delay write outside write-back phase");

  // The last write-back of the last section ends the filter run.
  a_run_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && (phase_q == PH_WR_S2) && last_stage) |=>
      (state_q == ST_DONE))
    else $error("filter run did not end after the last section");
`endif

endmodule

// ===== rtl/bcf_ram.sv =====
// ----------------------------------------------------------------------------
// bcf_ram: synchronous store with per-entry valid bits
// One write port, one registered read port; entries never written since
// reset or the last clear read as zero.
// ----------------------------------------------------------------------------
module bcf_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [WIDTH-1:0] rdata_q;
  logic             rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/bcf_dp.sv =====
// ----------------------------------------------------------------------------
// bcf_dp: shared multiply-accumulate datapath
// One multiplier and two accumulators compute all five products of a
// section, the rounded section output and the two new delay values.
// ----------------------------------------------------------------------------
module bcf_dp import bcf_pkg::*; (
  input  logic                clk_i,
  input  dp_ctrl_t            ctrl_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [COEFF_W-1:0]  coeff_i,
  input  logic [DLY_W-1:0]    dly_i,
  output logic [SAMPLE_W-1:0] x_o,
  output logic [DLY_W-1:0]    s1_o,
  output logic [DLY_W-1:0]    s2_o
);

  logic signed [SAMPLE_W-1:0] x_q, y_q, mul_op;
  logic signed [PROD_W-1:0]   prod_q;
  logic [ACC_W-1:0]           acc_q, acc2_q, term, dly_ext;
  logic [DLY_W-1:0]           yd_q;
  logic [DLY_W:0]             rnd;

  assign mul_op  = ctrl_i.mul_y ? y_q : x_q;
  // Truncating arithmetic shift of the product to delay scale.
  assign term    = {{(ACC_W-TERM_W){prod_q[PROD_W-1]}}, prod_q[PROD_W-1:PROD_SHIFT]};
  assign dly_ext = {{(ACC_W-DLY_W){dly_i[DLY_W-1]}}, dly_i};
  // Half an output LSB is added before the shift, so halves round up.
  assign rnd     = {yd_q[DLY_W-1], yd_q} + ((DLY_W+1)'(1) << (RND_SHIFT-1));

  function automatic logic [ACC_W-1:0] acc_next(input acc_op_e op,
                                                input logic [ACC_W-1:0] cur,
                                                input logic [ACC_W-1:0] t,
                                                input logic [ACC_W-1:0] d);
    logic [ACC_W-1:0] res;
    unique case (op)
      ACC_LOAD_DLY:  res = d;
      ACC_LOAD_TERM: res = t;
      ACC_ADD_TERM:  res = cur + t;
      ACC_SUB_TERM:  res = cur - t;
      default:       res = cur;
    endcase
    return res;
  endfunction

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= $signed(coeff_i) * mul_op;
    end
    acc_q  <= acc_next(ctrl_i.acc_op, acc_q, term, dly_ext);
    acc2_q <= acc_next(ctrl_i.acc2_op, acc2_q, term, dly_ext);
    if (ctrl_i.yd_en) begin
      yd_q <= sat_dly(acc_q);
    end
    if (ctrl_i.y_en) begin
      y_q <= sat_sample(rnd[DLY_W:RND_SHIFT]);
    end
    unique case (ctrl_i.x_op)
      X_LOAD_SAMPLE: x_q <= sample_i;
      X_LOAD_Y:      x_q <= y_q;
      default:       x_q <= x_q;
    endcase
  end

  assign x_o  = x_q;
  assign s1_o = sat_dly(acc2_q);
  assign s2_o = sat_dly(acc_q);

endmodule

// ===== verif/biquad_cascade_filter_top_tb.sv =====
// ----------------------------------------------------------------------------
// biquad_cascade_filter_top_tb: self-checking bench of the biquad cascade
// Drives commands, coefficient loads and register writes into the filter.
// A bit-exact fixed-point model of the five-section cascade predicts every
// output sample, and each returned sample is checked in order.
// ----------------------------------------------------------------------------
module biquad_cascade_filter_top_tb import bcf_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SECTIONS = 5;
  localparam int N_SLOTS    = N_SECTIONS * NCOEF;
  // Cycles that cover the longest filter transaction with margin.
  localparam int SETTLE_CYCLES = 9 * N_SECTIONS + 15;

  localparam logic [APB_ADDR_W-1:0] ADDR_FILTER_ENABLE = APB_ADDR_W'(4 * int'(REG_FILTER_ENABLE));
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED      = APB_ADDR_W'(4);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [COEFF_W-1:0]  COEFF_MAX  = {1'b0, {(COEFF_W-1){1'b1}}};
  localparam logic signed [COEFF_W-1:0]  COEFF_MIN  = {1'b1, {(COEFF_W-1){1'b0}}};
  // 1.0 in Q5.26.
  localparam logic signed [COEFF_W-1:0]  COEFF_UNITY = COEFF_W'(1) <<< COEFF_FRAC;

  // Action code 3 is not part of the enum; the block must ignore it.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEFF_W-1:0]  coeff_t;

  // --------------------------------------------------------------------------
  // Scoreboard. It keeps its own copy of the coefficient bank, the delay
  // bank and filter_enable, computes the output of every accepted filter
  // transaction and queues it. Returned samples are matched in order.
  // --------------------------------------------------------------------------
  class filter_scoreboard;
    longint  coeff_bank [N_SLOTS];
    longint  delay_bank [2*N_SECTIONS];
    bit      filter_on;
    sample_t expected_samples [$];
    int      failures;

    function new();
      foreach (coeff_bank[i]) coeff_bank[i] = 0;
      foreach (delay_bank[i]) delay_bank[i] = 0;
      filter_on = 1'b1;
      failures  = 0;
    endfunction

    static function longint clamp(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // Exact product, truncated down to the delay scale of 2^-39.
    static function longint scale_product(longint c, longint x);
      return (c * x) >>> PROD_SHIFT;
    endfunction

    function void note_command(logic [ACT_W-1:0] act, sample_t smp,
                               logic [IDX_W-1:0] idx, coeff_t val);
      longint x;
      longint yd;
      longint y;
      int     cb;
      int     db;
      case (act)
        ACT_WRITE: begin
          if (int'(idx) < N_SLOTS) coeff_bank[idx] = longint'(val);
        end
        ACT_CLEAR: begin
          foreach (delay_bank[i]) delay_bank[i] = 0;
        end
        ACT_FILTER: begin
          x = longint'(smp);
          if (filter_on) begin
            for (int s = 0; s < N_SECTIONS; s++) begin
              cb = s * NCOEF;
              db = s * 2;
              yd = clamp(scale_product(coeff_bank[cb+POS_B0], x) + delay_bank[db], DLY_W);
              // Round half up to the sample scale, then saturate.
              y  = clamp((yd + (longint'(1) << (RND_SHIFT - 1))) >>> RND_SHIFT, SAMPLE_W);
              delay_bank[db] = clamp(delay_bank[db+1]
                                     + scale_product(coeff_bank[cb+POS_B1], x)
                                     - scale_product(coeff_bank[cb+POS_A1], y), DLY_W);
              delay_bank[db+1] = clamp(scale_product(coeff_bank[cb+POS_B2], x)
                                       - scale_product(coeff_bank[cb+POS_A2], y), DLY_W);
              x = y;
            end
          end
          expected_samples.push_back(sample_t'(x));
        end
        default: ;
      endcase
    endfunction

    function void check_sample(sample_t got);
      sample_t want;
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected output sample %0d", $time, got);
        failures++;
      end else begin
        want = expected_samples.pop_front();
        if (got !== want) begin
          $display("%0t: sample_out mismatch, expected %0d, got %0d", $time, want, got);
          failures++;
        end
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // --------------------------------------------------------------------------
  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bcf_in_if  in_if ();
  bcf_out_if out_if ();

  biquad_cascade_filter_top #(
    .STAGES(N_SECTIONS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  filter_scoreboard sb;

  // When low, both sides run without gaps or stalls for a while, so that
  // back-to-back transactions are exercised too.
  bit gaps_on = 1'b1;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Every input of the block has a known value from time zero on.
  initial begin
    sb                 = new();
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_if.valid        = 1'b0;
    in_if.action       = ACT_FILTER;
    in_if.sample_in    = '0;
    in_if.coeff_index  = '0;
    in_if.coeff_value  = '0;
    out_if.ready       = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Output side. Every returned sample is checked at the edge where it is
  // taken. Before each result the sink draws a random stall while gaps are on.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_sample(out_if.sample_out);
    end
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = gaps_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  // --------------------------------------------------------------------------
  // Input side.
  // --------------------------------------------------------------------------

  // Sends one transaction after a random gap. Valid is left high after the
  // handshake so that a following transaction with no gap keeps it up; the
  // gap or stop_stream lowers it.
  task automatic send_command(input logic [ACT_W-1:0] act, input sample_t smp,
                              input logic [IDX_W-1:0] idx, input coeff_t val);
    int gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= act;
    in_if.sample_in   <= smp;
    in_if.coeff_index <= idx;
    in_if.coeff_value <= val;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_command(act, smp, idx, val);
  endtask

  task automatic send_sample(input sample_t smp);
    send_command(ACT_FILTER, smp, IDX_W'($urandom), coeff_t'($urandom));
  endtask

  task automatic send_coeff(input int slot, input coeff_t val);
    send_command(ACT_WRITE, sample_t'($urandom), IDX_W'(slot), val);
  endtask

  task automatic stop_stream();
    in_if.valid <= 1'b0;
  endtask

  // Waits until every predicted sample has come back, then lets the block
  // finish whatever it may still have in work.
  task automatic settle_block();
    stop_stream();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready. Only the
  // filter_enable address is decoded, and only bit 0 of the data counts.
  task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_FILTER_ENABLE) sb.filter_on = data[0];
  endtask

  // Tame coefficients stay within about +-2.0 so that the cascade keeps
  // doing real filtering; wild ones cover the whole Q5.26 range and its ends.
  function automatic coeff_t random_coeff(input bit tame);
    coeff_t c;
    c = coeff_t'($urandom);
    if (tame) return c >>> $urandom_range(4, 10);
    case ($urandom_range(0, 3))
      0:       return COEFF_MAX;
      1:       return COEFF_MIN;
      default: return c;
    endcase
  endfunction

  // Loads a full coefficient set, one write transaction per slot.
  task automatic load_coeff_set(input bit tame);
    for (int k = 0; k < N_SLOTS; k++) send_coeff(k, random_coeff(tame));
  endtask

  // Random traffic. Most transactions are samples through a loaded cascade;
  // the rest are coefficient rewrites, clears and the unused action code.
  // Ignored transactions do not count toward the total.
  task automatic run_random(input int n_items, input bit tame);
    int      done;
    int      pick;
    sample_t smp;
    logic [IDX_W-1:0] idx;
    done = 0;
    while (done < n_items) begin
      if (done % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      // Hold the sender once per phase until the block has drained.
      if (done == n_items / 2) settle_block();
      pick = $urandom_range(0, 99);
      if (pick < 74) begin
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 3))
              0:       smp = SAMPLE_MAX;
              1:       smp = SAMPLE_MIN;
              2:       smp = '0;
              default: smp = '1;
            endcase
          end
          1:       smp = sample_t'($signed(9'($urandom)));
          default: smp = sample_t'($urandom);
        endcase
        send_sample(smp);
        done++;
      end else if (pick < 90) begin
        idx = IDX_W'($urandom_range(0, 31));
        send_coeff(idx, random_coeff(tame && ($urandom_range(0, 7) != 0)));
        if (int'(idx) < N_SLOTS) done++;
      end else if (pick < 95) begin
        send_command(ACT_CLEAR, sample_t'($urandom), IDX_W'($urandom), coeff_t'($urandom));
        done++;
      end else begin
        send_command(ACT_UNUSED, sample_t'($urandom), IDX_W'($urandom), coeff_t'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset the cascade is enabled with all coefficients zero, so a
    // full-scale sample must come out as zero.
    send_sample(SAMPLE_MAX);

    // b0 = 1.0 in every section gives an identity cascade. Slots past the
    // end of the coefficient bank must be ignored.
    for (int s = 0; s < N_SECTIONS; s++) send_coeff(s * NCOEF + POS_B0, COEFF_UNITY);
    send_coeff(N_SLOTS, '1);
    send_coeff(31, COEFF_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample('1);
    send_sample('0);

    // The unused action code returns nothing and changes nothing.
    send_command(ACT_UNUSED, SAMPLE_MAX, '1, COEFF_MAX);

    // Extreme gain and feedback in the first section drive the delays and
    // the output into saturation.
    send_coeff(POS_B0, COEFF_MAX);
    send_coeff(POS_A1, COEFF_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(sample_t'(12345));

    // A clear must zero the delays, so the next output is just b0*x.
    send_command(ACT_CLEAR, '0, '0, '0);
    send_sample(sample_t'(1000));

    // Passthrough: only bit 0 of the written data counts, and the delay
    // state must be left alone.
    settle_block();
    write_register(ADDR_FILTER_ENABLE, 32'hFFFF_FFFE);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);

    // A write to an address other than filter_enable must be ignored.
    settle_block();
    write_register(ADDR_UNMAPPED, 32'h0000_0001);
    send_sample(sample_t'(4321));

    settle_block();
    write_register(ADDR_FILTER_ENABLE, 32'h0000_0001);
    send_sample(sample_t'(100));

    // Random phases: tame filters, passthrough, tame again after a clear,
    // and finally wild coefficients that saturate often.
    for (int p = 0; p < 4; p++) begin
      settle_block();
      write_register(ADDR_FILTER_ENABLE, (p == 1) ? 32'h0 : 32'h1);
      if (p != 1) begin
        send_command(ACT_CLEAR, '0, '0, '0);
        load_coeff_set(p != 3);
      end
      run_random(200, p != 3);
    end

    stop_stream();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
